[rtl/core/modular_exponentiation_assert.svh]
// Assertion macros for the modular exponentiation core.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_ASSERT_SVH
`define MODULAR_EXPONENTIATION_ASSERT_SVH

// check that cond implies result on the same edge
`define MEXP_ASSERT_IMPL(label, clk, rst_n, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (result)) \
        else $error(msg);

// check that cond implies result on the next edge
`define MEXP_ASSERT_NEXT(label, clk, rst_n, cond, result, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (result)) \
        else $error(msg);

`endif

[rtl/core/mexp_pkg.sv]
// Shared types and constants for the modular exponentiation core.
// No dependencies.
package mexp_pkg;
    localparam int DEF_WIDTH = 50;

    // operand selection for one modular multiply
    typedef enum logic [1:0] {OP_REDUCE, OP_SQUARE, OP_MULT} mexp_op_t;

    typedef struct packed {
        logic     load;       // latch base, exponent, modulus
        logic     start;      // load multiplier operands, clear accumulator
        logic     step;       // run one bit of the multiply
        logic     finish;     // commit product on the last step
        logic     next_bit;   // advance to the next lower exponent bit
        logic     out_load;   // copy result into output register
        mexp_op_t op;         // reduce base, square, or multiply by base
    } mexp_cmd_t;

    typedef struct packed {
        logic mul_last;   // last bit of the multiply in progress
        logic exp_bit;    // exponent bit at current position
        logic exp_last;   // at exponent bit zero
    } mexp_stat_t;
endpackage

[rtl/core/mexp_datapath.sv]
// Datapath: operand registers and a bit-serial interleaved modular multiplier.
// Depends on mexp_pkg.
module mexp_datapath
    import mexp_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mexp_cmd_t        cmd,
    output mexp_stat_t       stat,
    input  logic [WIDTH-1:0] in_base,
    input  logic [WIDTH-1:0] in_exponent,
    input  logic [WIDTH-1:0] modulus,
    output logic [WIDTH-1:0] power_result
);
    localparam int CW = $clog2(WIDTH);

    logic [WIDTH-1:0] base_reg, exp_reg, mod_reg, res_reg, acc_reg, x_reg, y_reg, out_reg;
    logic [CW-1:0]    mbit_reg, ebit_reg;
    logic             zero_reg;

    // one interleaved step: acc = 2*acc (+x) mod m
    logic [WIDTH+1:0] dbl, dbl_r, add, add_r;
    always_comb
    begin
        dbl   = {1'b0, acc_reg, 1'b0};
        dbl_r = (dbl >= {2'b00, mod_reg}) ? dbl - {2'b00, mod_reg} : dbl;
        add   = dbl_r + (y_reg[mbit_reg] ? {2'b00, x_reg} : '0);
        add_r = (add >= {2'b00, mod_reg}) ? add - {2'b00, mod_reg} : add;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbit_reg <= '0;
            ebit_reg <= '0;
        end
        else
        begin
            if (cmd.load)
                ebit_reg <= CW'(WIDTH - 1);
            else if (cmd.next_bit && ebit_reg != '0)
                ebit_reg <= ebit_reg - 1'b1;
            if (cmd.start)
                mbit_reg <= CW'(WIDTH - 1);
            else if (cmd.step && mbit_reg != '0)
                mbit_reg <= mbit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg <= in_base;
            exp_reg  <= in_exponent;
            mod_reg  <= modulus;
            zero_reg <= (modulus < WIDTH'(2));
            res_reg  <= WIDTH'(1);
        end
        if (cmd.start)
        begin
            acc_reg <= '0;
            case (cmd.op)
                // 1 * base walks the base bits in, two conditional subtracts each
                OP_REDUCE:
                begin
                    x_reg <= WIDTH'(1);
                    y_reg <= base_reg;
                end
                OP_SQUARE:
                begin
                    x_reg <= res_reg;
                    y_reg <= res_reg;
                end
                OP_MULT:
                begin
                    x_reg <= res_reg;
                    y_reg <= base_reg;
                end
                default:
                begin
                    x_reg <= res_reg;
                    y_reg <= res_reg;
                end
            endcase
        end
        else if (cmd.step)
            acc_reg <= add_r[WIDTH-1:0];
        if (cmd.finish)
        begin
            if (cmd.op == OP_REDUCE)
                base_reg <= add_r[WIDTH-1:0];
            else
                res_reg <= add_r[WIDTH-1:0];
        end
        if (cmd.out_load)
            out_reg <= zero_reg ? '0 : res_reg;
    end

    assign stat.mul_last = (mbit_reg == '0);
    assign stat.exp_bit  = exp_reg[ebit_reg];
    assign stat.exp_last = (ebit_reg == '0);
    assign power_result  = out_reg;
endmodule

[rtl/core/mexp_ctrl.sv]
// Controller state machine sequencing squarings and multiplications.
// Depends on mexp_pkg.
module mexp_ctrl
    import mexp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    output mexp_cmd_t  cmd,
    input  mexp_stat_t stat
);
    typedef enum logic [2:0] {S_IDLE, S_RED, S_SQ, S_MUL, S_DONE} state_t;
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   first_reg, first_next;

    // unit free while only the output word waits
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        first_next = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    first_next = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED:
            begin
                cmd.op = OP_REDUCE;
                if (first_reg)
                    cmd.start = 1'b1;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.mul_last)
                    begin
                        cmd.finish = 1'b1;
                        first_next = 1'b1;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                cmd.op = OP_SQUARE;
                if (first_reg)
                    cmd.start = 1'b1;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.mul_last)
                    begin
                        cmd.finish = 1'b1;
                        first_next = 1'b1;
                        if (stat.exp_bit)
                            state_next = S_MUL;
                        else if (stat.exp_last)
                            state_next = S_DONE;
                        else
                        begin
                            cmd.next_bit = 1'b1;
                            state_next   = S_SQ;
                        end
                    end
                end
            end
            S_MUL:
            begin
                cmd.op = OP_MULT;
                if (first_reg)
                    cmd.start = 1'b1;
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.mul_last)
                    begin
                        cmd.finish = 1'b1;
                        first_next = 1'b1;
                        if (stat.exp_last)
                            state_next = S_DONE;
                        else
                        begin
                            cmd.next_bit = 1'b1;
                            state_next   = S_SQ;
                        end
                    end
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            first_reg <= first_next;
        end
    end
endmodule

[rtl/core/modular_exponentiation.sv]
// Modular exponentiation: base^exponent mod modulus, one result per input word.
// Input slave channel s_axis_* carries {exponent, base}; result on m_axis_*.
// Modulus written through cfg_wr_en / cfg_wr_data, reset value 2; the user
// must write it only while idle, the block does not enforce this. Each input
// word: one base reduction, then for every one of WIDTH exponent bits a
// squaring and, for a set bit, a multiply by the base. Each modular multiply
// runs on one shared bit-serial unit, so a new input word is taken only once
// the result of the last word is in the output register.
// A result sits in the output register until taken; the next word is
// accepted meanwhile. A stalled receiver holds the finished word, the next
// word is computed and waits in the unit, and the input stalls behind it.
// Reset clears the controller and output valid; modulus returns to 2.
// Modulus below 2 gives 0 for every word.
`include "modular_exponentiation_assert.svh"

module modular_exponentiation
    import mexp_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [WIDTH-1:0]             cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // base [WIDTH-1:0], exponent [2*WIDTH-1:WIDTH], zero fill
    input  logic [((2*WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // power_result [WIDTH-1:0], zero fill
    output logic [((WIDTH+7)/8)*8-1:0]   m_axis_tdata
);
    localparam int OW = ((WIDTH+7)/8)*8;

    logic [WIDTH-1:0] mod_reg, power_result;
    mexp_cmd_t  cmd;
    mexp_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mod_reg <= WIDTH'(2);
        else if (cfg_wr_en)
            mod_reg <= cfg_wr_data;
    end

    mexp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .stat(stat)
    );

    mexp_datapath #(.WIDTH(WIDTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_base(s_axis_tdata[WIDTH-1:0]),
        .in_exponent(s_axis_tdata[2*WIDTH-1:WIDTH]),
        .modulus(mod_reg),
        .power_result(power_result)
    );

    assign m_axis_tdata = OW'(power_result);

    `MEXP_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
    `MEXP_ASSERT_NEXT(a_accept_busy, clk, rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "input taken while the unit is busy")
    `MEXP_ASSERT_IMPL(a_cfg_idle, clk, rst_n, cfg_wr_en,
        s_axis_tready && !m_axis_tvalid, "modulus written while a word is in flight")
endmodule
